/* rtl/stu_pkg.sv */
// ----------------------------------------------------------------------------
// stu_pkg
// Shared types, token kind codes, character constants and classifiers for
// the source tokenizer.
// ----------------------------------------------------------------------------
package stu_pkg;

  localparam int DEF_OFFSET_BITS = 20;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam int START_W = 20;
  localparam int LEN_W   = 21;
  localparam int VAL_W   = 31;
  localparam int KIND_W  = 5;

  localparam logic [LEN_W-1:0] LEN_MAX = 21'h100000;
  localparam logic [VAL_W-1:0] NUM_MAX = 31'h7FFF_FFFF;

  localparam logic [KIND_W-1:0] KIND_IDENT      = 5'd0;
  localparam logic [KIND_W-1:0] KIND_FUNCTION   = 5'd1;
  localparam logic [KIND_W-1:0] KIND_DEFINE     = 5'd2;
  localparam logic [KIND_W-1:0] KIND_RETURN     = 5'd3;
  localparam logic [KIND_W-1:0] KIND_AS         = 5'd4;
  localparam logic [KIND_W-1:0] KIND_INT        = 5'd5;
  localparam logic [KIND_W-1:0] KIND_CALL       = 5'd6;
  localparam logic [KIND_W-1:0] KIND_NUMBER     = 5'd7;
  localparam logic [KIND_W-1:0] KIND_LBRACE     = 5'd8;
  localparam logic [KIND_W-1:0] KIND_RBRACE     = 5'd9;
  localparam logic [KIND_W-1:0] KIND_LPAREN     = 5'd10;
  localparam logic [KIND_W-1:0] KIND_RPAREN     = 5'd11;
  localparam logic [KIND_W-1:0] KIND_ASSIGN     = 5'd12;
  localparam logic [KIND_W-1:0] KIND_SEMI       = 5'd13;
  localparam logic [KIND_W-1:0] KIND_PLUS       = 5'd14;
  localparam logic [KIND_W-1:0] KIND_MINUS      = 5'd15;
  localparam logic [KIND_W-1:0] KIND_STAR       = 5'd16;
  localparam logic [KIND_W-1:0] KIND_SLASH      = 5'd17;
  localparam logic [KIND_W-1:0] KIND_BAD_NUMBER = 5'd18;
  localparam logic [KIND_W-1:0] KIND_BAD_CHAR   = 5'd19;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ASSIGN = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [63:0] KW_FUNCTION = 64'h6675_6E63_7469_6F6E;
  localparam logic [63:0] KW_DEFINE   = 64'h0000_6465_6669_6E65;
  localparam logic [63:0] KW_RETURN   = 64'h0000_7265_7475_726E;
  localparam logic [63:0] KW_AS       = 64'h0000_0000_0000_6173;
  localparam logic [63:0] KW_INT      = 64'h0000_0000_0069_6E74;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_PAREN,
    MODE_NUMBER,
    MODE_HALT
  } scan_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic [VAL_W-1:0]   value;
  } tok_t;

  // up to three tokens caused by one source byte, oldest in slot 0
  typedef struct packed {
    logic [1:0]     cnt;
    tok_t [2:0]     tok;
  } burst_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]}) || (c == CH_UNDER);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic [KIND_W:0] punct_kind(logic [7:0] c);
    logic [KIND_W:0] r;
    case (c)
      CH_LBRACE: r = {1'b1, KIND_LBRACE};
      CH_RBRACE: r = {1'b1, KIND_RBRACE};
      CH_LPAREN: r = {1'b1, KIND_LPAREN};
      CH_RPAREN: r = {1'b1, KIND_RPAREN};
      CH_ASSIGN: r = {1'b1, KIND_ASSIGN};
      CH_SEMI:   r = {1'b1, KIND_SEMI};
      CH_PLUS:   r = {1'b1, KIND_PLUS};
      CH_MINUS:  r = {1'b1, KIND_MINUS};
      CH_STAR:   r = {1'b1, KIND_STAR};
      CH_SLASH:  r = {1'b1, KIND_SLASH};
      default:   r = {1'b0, KIND_BAD_CHAR};
    endcase
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] word_kind(logic [63:0] prefix, logic [LEN_W-1:0] run);
    logic [KIND_W-1:0] k;
    k = KIND_IDENT;
    if (run == 21'd8 && prefix == KW_FUNCTION) k = KIND_FUNCTION;
    else if (run == 21'd6 && prefix == KW_DEFINE) k = KIND_DEFINE;
    else if (run == 21'd6 && prefix == KW_RETURN) k = KIND_RETURN;
    else if (run == 21'd2 && prefix == KW_AS) k = KIND_AS;
    else if (run == 21'd3 && prefix == KW_INT) k = KIND_INT;
    return k;
  endfunction

endpackage

/* rtl/stu_front.sv */
// ----------------------------------------------------------------------------
// stu_front
// Scanner: takes one source byte per beat, tracks the open word or number
// and packs the tokens that byte completes into one queue entry.
// ----------------------------------------------------------------------------
module stu_front import stu_pkg::*; #(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_source_byte,
  input  logic       in_stream_last,
  input  q_stat_t    q_stat,
  output logic       q_wr,
  output burst_t     q_wdata
);

  scan_mode_t             mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [63:0]            prefix_r, prefix_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [LEN_W-1:0]       run_r, run_nxt;
  logic [VAL_W-1:0]       acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                   accept;
  tok_t [2:0]             toks;
  logic [1:0]             cnt;
  logic                   do_sb;
  logic [LEN_W-1:0]       run_grow;
  logic [34:0]            prod;
  logic [KIND_W-1:0]      wk;
  logic [KIND_W:0]        pk;
  logic [7:0]             c;

  function automatic tok_t mk_tok(logic [KIND_W-1:0] k, logic [OFFSET_BITS-1:0] s,
                                  logic [LEN_W:0] l, logic [VAL_W-1:0] v);
    tok_t t;
    t.kind   = k;
    t.start  = START_W'(s);
    t.length = (l > (LEN_W+1)'(LEN_MAX)) ? LEN_MAX : LEN_W'(l);
    t.value  = v;
    return t;
  endfunction

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign c        = in_source_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pos_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prefix_r <= prefix_nxt;
      start_r  <= start_nxt;
      run_r    <= run_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    prefix_nxt = prefix_r;
    start_nxt  = start_r;
    run_nxt    = run_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    toks       = '0;
    cnt        = 2'd0;
    do_sb      = 1'b0;
    run_grow   = (run_r < LEN_MAX) ? run_r + 21'd1 : run_r;
    // c - '0' is the low nibble for digit bytes
    prod       = (35'(acc_r) << 3) + (35'(acc_r) << 1) + 35'(c[3:0]);
    wk         = word_kind(prefix_r, run_r);
    pk         = punct_kind(c);

    case (mode_r)
      MODE_WORD: begin
        if (is_alpha(c)) begin
          if (run_r < 21'd8) prefix_nxt = {prefix_r[55:0], c};
          run_nxt = run_grow;
        end else if ((wk != KIND_IDENT && wk != KIND_INT) || c != CH_LPAREN) begin
          toks[cnt] = mk_tok(wk, start_r, {1'b0, run_r}, '0);
          cnt = cnt + 2'd1;
          do_sb = 1'b1;
        end else begin
          mode_nxt = MODE_PAREN;
        end
      end
      MODE_PAREN: begin
        if (c == CH_RPAREN) begin
          toks[cnt] = mk_tok(KIND_CALL, start_r, {1'b0, run_r} + 22'd2, '0);
          cnt = cnt + 2'd1;
          mode_nxt = MODE_IDLE;
        end else begin
          toks[cnt] = mk_tok(wk, start_r, {1'b0, run_r}, '0);
          cnt = cnt + 2'd1;
          toks[cnt] = mk_tok(KIND_LPAREN, pos_r - OFFSET_BITS'(1), 22'd1, '0);
          cnt = cnt + 2'd1;
          do_sb = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          if (!ovf_r) begin
            if (prod > 35'(NUM_MAX)) begin
              ovf_nxt = 1'b1;
              acc_nxt = '0;
            end else begin
              acc_nxt = VAL_W'(prod);
            end
          end
          run_nxt = run_grow;
        end else if (ovf_r) begin
          toks[cnt] = mk_tok(KIND_BAD_NUMBER, start_r, {1'b0, run_r}, '0);
          cnt = cnt + 2'd1;
          mode_nxt = MODE_HALT;
        end else begin
          toks[cnt] = mk_tok(KIND_NUMBER, start_r, {1'b0, run_r}, acc_r);
          cnt = cnt + 2'd1;
          do_sb = 1'b1;
        end
      end
      MODE_HALT: begin
      end
      default: begin
        do_sb = 1'b1;
      end
    endcase

    // start of a fresh token with the current byte
    if (do_sb) begin
      mode_nxt = MODE_IDLE;
      if (is_space(c)) begin
      end else if (is_alpha(c)) begin
        mode_nxt   = MODE_WORD;
        start_nxt  = pos_r;
        run_nxt    = 21'd1;
        prefix_nxt = {56'd0, c};
      end else if (is_digit(c)) begin
        mode_nxt  = MODE_NUMBER;
        start_nxt = pos_r;
        run_nxt   = 21'd1;
        acc_nxt   = VAL_W'(c[3:0]);
        ovf_nxt   = 1'b0;
      end else if (pk[KIND_W]) begin
        toks[cnt] = mk_tok(pk[KIND_W-1:0], pos_r, 22'd1, '0);
        cnt = cnt + 2'd1;
      end else begin
        toks[cnt] = mk_tok(KIND_BAD_CHAR, pos_r, 22'd1, '0);
        cnt = cnt + 2'd1;
        mode_nxt = MODE_HALT;
      end
    end

    pos_nxt = pos_r + OFFSET_BITS'(1);

    // end of stream: flush the open token and return to idle
    if (in_stream_last) begin
      case (mode_nxt)
        MODE_WORD: begin
          toks[cnt] = mk_tok(word_kind(prefix_nxt, run_nxt), start_nxt,
                             {1'b0, run_nxt}, '0);
          cnt = cnt + 2'd1;
        end
        MODE_PAREN: begin
          toks[cnt] = mk_tok(word_kind(prefix_nxt, run_nxt), start_nxt,
                             {1'b0, run_nxt}, '0);
          cnt = cnt + 2'd1;
          toks[cnt] = mk_tok(KIND_LPAREN, pos_r, 22'd1, '0);
          cnt = cnt + 2'd1;
        end
        MODE_NUMBER: begin
          if (ovf_nxt) begin
            toks[cnt] = mk_tok(KIND_BAD_NUMBER, start_nxt, {1'b0, run_nxt}, '0);
          end else begin
            toks[cnt] = mk_tok(KIND_NUMBER, start_nxt, {1'b0, run_nxt}, acc_nxt);
          end
          cnt = cnt + 2'd1;
        end
        default: begin
        end
      endcase
      mode_nxt = MODE_IDLE;
      pos_nxt  = '0;
    end
  end

  assign q_wr          = accept && (cnt != 2'd0);
  assign q_wdata.cnt   = cnt;
  assign q_wdata.tok   = toks;

endmodule

/* rtl/stu_queue.sv */
// ----------------------------------------------------------------------------
// stu_queue
// Short FIFO of token bursts between the scanner and the output stage.
// ----------------------------------------------------------------------------
module stu_queue import stu_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  burst_t  wr_data,
  input  logic    rd_en,
  output burst_t  rd_data,
  output q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  burst_t         mem_r [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (rd_en) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  assign rd_data    = mem_r[rp_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

/* rtl/stu_back.sv */
// ----------------------------------------------------------------------------
// stu_back
// Output stage: walks the head burst one token per beat and marks the last
// token of each burst.
// ----------------------------------------------------------------------------
module stu_back import stu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  q_stat_t             q_stat,
  input  burst_t              q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   out_token_kind,
  output logic [START_W-1:0]  out_token_start,
  output logic [LEN_W-1:0]    out_token_length,
  output logic [VAL_W-1:0]    out_number_value,
  output logic                out_run_last
);

  logic [1:0] sel_r, sel_nxt;
  tok_t       cur;
  logic       is_last;
  logic       beat;

  assign cur     = q_head.tok[sel_r];
  assign is_last = (sel_r == q_head.cnt - 2'd1);
  assign beat    = out_valid && out_ready;
  assign q_pop   = beat && is_last;

  always_comb begin
    sel_nxt = sel_r;
    if (beat) begin
      sel_nxt = is_last ? 2'd0 : sel_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 2'd0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  assign out_valid        = !q_stat.empty;
  assign out_token_kind   = cur.kind;
  assign out_token_start  = cur.start;
  assign out_token_length = cur.length;
  assign out_number_value = cur.value;
  assign out_run_last     = is_last;

endmodule

/* rtl/source_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// source_tokenizer_unit
// Streaming lexical tokenizer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while the token queue (QUEUE_DEPTH
// bursts) has room; the scanner decodes bytes combinationally. A byte yields
// zero to three tokens, which leave the output port one per cycle while
// out_ready is high, so the output port sets the rate whenever bytes
// produce more than one token on average; otherwise one byte per cycle
// holds. A token is queued as its completing byte is accepted. out_run_last
// marks the last token from one byte. After a bad number or bad character,
// bytes are consumed without output until stream_last, which flushes any
// open token and restarts offsets at zero.
// ----------------------------------------------------------------------------
module source_tokenizer_unit import stu_pkg::*; #(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_source_byte,
  input  logic                in_stream_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   out_token_kind,
  output logic [START_W-1:0]  out_token_start,
  output logic [LEN_W-1:0]    out_token_length,
  output logic [VAL_W-1:0]    out_number_value,
  output logic                out_run_last
);

  q_stat_t q_stat;
  logic    q_wr;
  logic    q_pop;
  burst_t  q_wdata;
  burst_t  q_head;

  stu_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_source_byte (in_source_byte),
    .in_stream_last (in_stream_last),
    .q_stat         (q_stat),
    .q_wr           (q_wr),
    .q_wdata        (q_wdata)
  );

  stu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .stat    (q_stat)
  );

  stu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_number_value (out_number_value),
    .out_run_last     (out_run_last)
  );

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= KIND_BAD_CHAR)
    else $error("token kind out of range");

  a_value_only_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != KIND_NUMBER |-> out_number_value == '0)
    else $error("nonzero value on non-number token");

  a_single_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_token_kind >= KIND_LBRACE && out_token_kind <= KIND_SLASH) ||
                  out_token_kind == KIND_BAD_CHAR) |-> out_token_length == 21'd1)
    else $error("punctuation token length not one");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_length != '0 && out_token_length <= LEN_MAX)
    else $error("token length out of range");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !q_wr)
    else $error("queue written while full");

endmodule
